// ===== src/mts_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mts_pkg: shared types and constants for the min-tracking stack.
// Holds the word formats of both channels, the status and action codes,
// the controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package mts_pkg;

  // Default number of stack entries.
  localparam int STACK_DEPTH = 256;

  // Minimum reported while the stack is empty.
  localparam logic signed [31:0] EMPTY_MIN = 32'sh7FFF_FFFF;

  // Action codes of a request word.
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  // Status codes of a response word.
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_t;

  // Request word.
  typedef struct packed {
    logic               action;
    logic signed [31:0] push_value;
  } req_word_t;

  // Response word.
  typedef struct packed {
    logic signed [31:0] top_value;
    logic [8:0]         entry_count;
    logic               is_empty;
    logic signed [31:0] min_value;
    logic [1:0]         status;
  } rsp_word_t;

  // One stack entry: its value and the minimum up to and including it.
  typedef struct packed {
    logic signed [31:0] val;
    logic signed [31:0] min;
  } entry_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FETCH,
    S_OUT
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the request word
    logic exec;    // carry out the push or pop
    logic refill;  // load the top registers from the memory read data
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_fetch;  // the pop exposes an entry that must be read back
  } dp_status_t;

endpackage
`default_nettype wire

// ===== src/min_tracking_stack_top.sv =====
// ----------------------------------------------------------------------------
// min_tracking_stack_top: bounded stack of signed words with minimum tracking.
// Sequence: a word is taken in S_IDLE and run in S_EXEC; a pop that exposes
//   a stored entry then passes S_FETCH (one registered read of the entry
//   memory) before S_OUT shows the response. The controller runs one word
//   at a time and takes the next the cycle after the response is taken.
// Reset: synchronous; empties the stack. Memory contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module min_tracking_stack_top #(
  parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire mts_pkg::req_word_t req_word,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output mts_pkg::rsp_word_t      rsp_word
);

  mts_pkg::dp_cmd_t    cmd;
  mts_pkg::dp_status_t stat;

  // Sequencer.
  mts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Storage and arithmetic.
  mts_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .req_word (req_word),
    .rsp_word (rsp_word)
  );

endmodule
`default_nettype wire

// ===== src/mts_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mts_datapath: storage and arithmetic of the min-tracking stack.
// The entry memory holds every entry; the top entry is also cached in
// registers so the response can be formed without a memory read.
// ----------------------------------------------------------------------------
module mts_datapath #(
  parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mts_pkg::dp_cmd_t   cmd,
  output mts_pkg::dp_status_t     stat,
  input  wire mts_pkg::req_word_t req_word,
  output mts_pkg::rsp_word_t      rsp_word
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  mts_pkg::entry_t    mem [STACK_DEPTH];
  mts_pkg::entry_t    rd_data;
  logic [CW-1:0]      count;
  logic               cur_action;
  logic signed [31:0] cur_value;
  logic signed [31:0] top_val;
  logic signed [31:0] top_min;
  mts_pkg::status_t   status_q;

  logic               is_full;
  logic               is_zero;
  logic signed [31:0] new_min;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;

  // Decode of the current count and the running minimum for a push.
  always_comb begin
    is_full = (count == CW'(STACK_DEPTH));
    is_zero = (count == '0);
    new_min = (!is_zero && (top_min < cur_value)) ? top_min : cur_value;
    wr_addr = count[AW-1:0];
    rd_addr = AW'(count - CW'(2));
    stat.need_fetch = (cur_action == mts_pkg::ACT_POP) && (count >= CW'(2));
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_action <= req_word.action;
      cur_value  <= req_word.push_value;
    end
  end

  // Entry count and status.
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      status_q <= mts_pkg::ST_DONE;
    end else if (cmd.exec) begin
      if (cur_action == mts_pkg::ACT_PUSH) begin
        if (is_full) begin
          status_q <= mts_pkg::ST_PUSH_FULL;
        end else begin
          count    <= count + CW'(1);
          status_q <= mts_pkg::ST_DONE;
        end
      end else begin
        if (is_zero) begin
          status_q <= mts_pkg::ST_POP_EMPTY;
        end else begin
          count    <= count - CW'(1);
          status_q <= mts_pkg::ST_DONE;
        end
      end
    end
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (cur_action == mts_pkg::ACT_PUSH && !is_full) begin
        mem[wr_addr] <= '{val: cur_value, min: new_min};
      end
      rd_data <= mem[rd_addr];
    end
  end

  // Cached top entry.
  always_ff @(posedge clk) begin
    if (cmd.exec && cur_action == mts_pkg::ACT_PUSH && !is_full) begin
      top_val <= cur_value;
      top_min <= new_min;
    end else if (cmd.refill) begin
      top_val <= rd_data.val;
      top_min <= rd_data.min;
    end
  end

  // Response word from the registered state.
  always_comb begin
    rsp_word.entry_count = 9'(count);
    rsp_word.status      = status_q;
    if (is_zero) begin
      rsp_word.top_value = '0;
      rsp_word.min_value = mts_pkg::EMPTY_MIN;
      rsp_word.is_empty  = 1'b1;
    end else begin
      rsp_word.top_value = top_val;
      rsp_word.min_value = top_min;
      rsp_word.is_empty  = 1'b0;
    end
  end

  // The count never runs past the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stack count exceeds capacity");

  // A push with room adds exactly one entry.
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && cur_action == mts_pkg::ACT_PUSH && !is_full)
      |=> (count == $past(count) + CW'(1)))
    else $error("push did not add one entry");

  // A pop on a non-empty stack removes exactly one entry.
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && cur_action == mts_pkg::ACT_POP && !is_zero)
      |=> (count == $past(count) - CW'(1)))
    else $error("pop did not remove one entry");

  // The cached minimum never exceeds the cached top value.
  a_min_order: assert property (@(posedge clk) disable iff (rst)
    !is_zero |-> (top_min <= top_val))
    else $error("top minimum above top value");

endmodule
`default_nettype wire

// ===== src/mts_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mts_ctrl: sequencer of the min-tracking stack.
// Takes one word at a time, runs the operation, refills the top entry
// after a pop when needed and holds the response until it is taken.
// ----------------------------------------------------------------------------
module mts_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_stall,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output mts_pkg::dp_cmd_t         cmd,
  input  wire mts_pkg::dp_status_t stat
);

  mts_pkg::ctl_state_t state;
  mts_pkg::ctl_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mts_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    rsp_valid  = 1'b0;
    unique case (state)
      mts_pkg::S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = mts_pkg::S_EXEC;
        end
      end
      mts_pkg::S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.need_fetch ? mts_pkg::S_FETCH : mts_pkg::S_OUT;
      end
      mts_pkg::S_FETCH: begin
        cmd.refill = 1'b1;
        state_next = mts_pkg::S_OUT;
      end
      mts_pkg::S_OUT: begin
        rsp_valid = 1'b1;
        if (!rsp_stall) begin
          state_next = mts_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mts_pkg::S_IDLE;
      end
    endcase
  end

  // An accepted word is always followed by its execution step.
  a_load_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.exec)
    else $error("accepted word was not executed");

  // A refill only follows an execution step.
  a_refill_after_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.refill |-> $past(cmd.exec))
    else $error("refill without a preceding execution");

  // No new word is taken while a response is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> req_stall)
    else $error("request taken while response pending");

endmodule
`default_nettype wire
